// File: src/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Types and constants shared by the barometer pressure compensation block.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int COEFF_W = 16;
    localparam int WORD_W  = 16;
    localparam int ADC_W   = 10;
    localparam int PROD1_W = 27;
    localparam int PROD2_W = 38;
    localparam int SUM_W   = 39;
    localparam int NUM_W   = 50;
    localparam int QUO_W   = 26;
    localparam int LOW_W   = 23;
    localparam int OUT_W   = 12;

    // (800 + 1/2) * 1023 * 2^24 written as 1601 * 1023 * 2^23
    localparam logic signed [NUM_W-1:0] NUM_BIAS = 50'sd1637823 <<< 23;
    // smallest quotient input that rounds above the output range
    localparam logic signed [QUO_W-1:0] OVER_LIMIT = 26'sd4190208;
    // floor(2^32 / 1023)
    localparam logic [LOW_W-1:0]        RECIP_1023 = 23'd4198404;
    localparam logic [ADC_W-1:0]        DIV_CONST  = 10'd1023;
    localparam logic [OUT_W-1:0]        OUT_MAX    = 12'd4095;

    typedef enum logic [1:0] {
        REG_OFFSET      = 2'd0,
        REG_SENSITIVITY = 2'd1,
        REG_TEMP_OFFSET = 2'd2,
        REG_TEMP_SENS   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [WORD_W-1:0] pressure_word;
        logic [WORD_W-1:0] temperature_word;
    } in_t;

    typedef struct packed {
        logic [OUT_W-1:0] pressure_sixteenths;
        logic             clipped;
    } out_t;

    typedef struct packed {
        logic signed [COEFF_W-1:0] offset_coeff;
        logic signed [COEFF_W-1:0] sensitivity_coeff;
        logic signed [COEFF_W-1:0] temp_offset_coeff;
        logic signed [COEFF_W-1:0] temp_sens_coeff;
    } coeff_t;

endpackage

// File: src/barometer_pressure_compensation.sv
// ----------------------------------------------------------------------------
// barometer_pressure_compensation
// Compensated barometric pressure from raw pressure and temperature words.
// ----------------------------------------------------------------------------
// One pressure/temperature pair is taken per cycle while the output side
// is not stalled, and each transaction passes through six register stages
// (three for the exact polynomial sum, three for the scaling by 1/1023 and
// clamp) before yielding one result. Only the top ten bits of each input
// word are used. The output is pressure in 1/16 kPa, clamped to 0..4095
// with clipped set when the limit was hit. Coefficients are to be written
// through the configuration port only while no transaction is in flight;
// the block itself does not enforce this.
module barometer_pressure_compensation import bpc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_addr,
    input  logic [COEFF_W-1:0] cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_t                s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output out_t               m_data
);

    coeff_t                  coeff;
    logic                    sum_valid;
    logic                    sum_ready;
    logic signed [SUM_W-1:0] sum;

    bpc_cfg_regs u_cfg_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .coeff       (coeff)
    );

    bpc_poly u_poly (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .coeff     (coeff),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .out_sum   (sum)
    );

    bpc_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sum_valid),
        .in_ready  (sum_ready),
        .in_sum    (sum),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

// File: src/bpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bpc_cfg_regs
// Coefficient register file written through the plain configuration port.
// ----------------------------------------------------------------------------
module bpc_cfg_regs import bpc_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_addr,
    input  logic [COEFF_W-1:0] cfg_wr_data,
    output coeff_t             coeff
);

    coeff_t coeff_reg;
    coeff_t coeff_next;

    always_comb begin
        coeff_next = coeff_reg;
        if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_OFFSET:      coeff_next.offset_coeff      = cfg_wr_data;
                REG_SENSITIVITY: coeff_next.sensitivity_coeff = cfg_wr_data;
                REG_TEMP_OFFSET: coeff_next.temp_offset_coeff = cfg_wr_data;
                REG_TEMP_SENS:   coeff_next.temp_sens_coeff   = cfg_wr_data;
                default:         coeff_next = coeff_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_reg <= '0;
        end else begin
            coeff_reg <= coeff_next;
        end
    end

    assign coeff = coeff_reg;

endmodule

// File: src/bpc_poly.sv
// ----------------------------------------------------------------------------
// bpc_poly
// Three-stage pipeline forming the exact compensation sum with 24 fraction
// bits: products, then second product and linear terms, then final add.
// ----------------------------------------------------------------------------
module bpc_poly import bpc_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  coeff_t                  coeff,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  in_t                     in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [SUM_W-1:0] out_sum
);

    logic                      v1_reg, v2_reg, v3_reg;
    logic                      v1_next, v2_next, v3_next;
    logic                      en1, en2, en3;

    logic signed [ADC_W:0]     p_s, t_s;
    logic signed [ADC_W:0]     p_reg;
    logic signed [PROD1_W-1:0] bp_reg, ct_reg, b2t_reg;
    logic signed [PROD2_W-1:0] ctp_reg;
    logic signed [SUM_W-1:0]   lin_reg, lin_next;
    logic signed [SUM_W-1:0]   sum_reg;

    assign en3 = !v3_reg || out_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign v1_next = en1 ? in_valid : v1_reg;
    assign v2_next = en2 ? v1_reg   : v2_reg;
    assign v3_next = en3 ? v2_reg   : v3_reg;

    assign p_s = $signed({1'b0, in_data.pressure_word[WORD_W-1 -: ADC_W]});
    assign t_s = $signed({1'b0, in_data.temperature_word[WORD_W-1 -: ADC_W]});

    always_comb begin
        lin_next = (SUM_W'(coeff.offset_coeff) <<< 21)
                 + (SUM_W'(bp_reg) <<< 11)
                 + (SUM_W'(b2t_reg) <<< 10);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            p_reg   <= p_s;
            bp_reg  <= coeff.sensitivity_coeff * p_s;
            ct_reg  <= coeff.temp_sens_coeff * t_s;
            b2t_reg <= coeff.temp_offset_coeff * t_s;
        end
        if (en2) begin
            ctp_reg <= ct_reg * p_reg;
            lin_reg <= lin_next;
        end
        if (en3) begin
            sum_reg <= lin_reg + SUM_W'(ctp_reg);
        end
    end

    assign in_ready  = en1;
    assign out_valid = v3_reg;
    assign out_sum   = sum_reg;

endmodule

// File: src/bpc_scale.sv
// ----------------------------------------------------------------------------
// bpc_scale
// Three-stage pipeline turning the sum into 1/16 kPa: scale and bias,
// reciprocal multiply by 1/1023 with range checks, then correction and clamp.
// ----------------------------------------------------------------------------
module bpc_scale import bpc_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [SUM_W-1:0] in_sum,
    output logic                    out_valid,
    input  logic                    out_ready,
    output out_t                    out_data
);

    logic                        v4_reg, v5_reg, v6_reg;
    logic                        v4_next, v5_next, v6_next;
    logic                        en4, en5, en6;

    logic signed [NUM_W-1:0]     num;
    logic signed [QUO_W-1:0]     n1_reg;
    logic [2*LOW_W-1:0]          recip_prod;
    logic [LOW_W-1:0]            low_reg;
    logic [OUT_W-1:0]            qest_reg;
    logic                        neg_reg, over_reg;
    logic [LOW_W-1:0]            rem;
    logic [OUT_W-1:0]            quo;
    out_t                        res_reg, res_next;

    assign en6 = !v6_reg || out_ready;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;

    assign v4_next = en4 ? in_valid : v4_reg;
    assign v5_next = en5 ? v4_reg   : v5_reg;
    assign v6_next = en6 ? v5_reg   : v6_reg;

    // 1040 * s + bias
    assign num = (NUM_W'(in_sum) <<< 10) + (NUM_W'(in_sum) <<< 4) + NUM_BIAS;

    assign recip_prod = n1_reg[LOW_W-1:0] * RECIP_1023;

    always_comb begin
        rem = low_reg - ((LOW_W'(qest_reg) << ADC_W) - LOW_W'(qest_reg));
        quo = (rem >= LOW_W'(DIV_CONST)) ? qest_reg + 1'b1 : qest_reg;
        res_next.clipped = neg_reg || over_reg;
        if (neg_reg) begin
            res_next.pressure_sixteenths = '0;
        end else if (over_reg) begin
            res_next.pressure_sixteenths = OUT_MAX;
        end else begin
            res_next.pressure_sixteenths = quo;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            v4_reg <= v4_next;
            v5_reg <= v5_next;
            v6_reg <= v6_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            n1_reg <= num[NUM_W-1:24];
        end
        if (en5) begin
            neg_reg  <= n1_reg[QUO_W-1];
            over_reg <= n1_reg >= OVER_LIMIT;
            low_reg  <= n1_reg[LOW_W-1:0];
            qest_reg <= recip_prod[32 +: OUT_W];
        end
        if (en6) begin
            res_reg <= res_next;
        end
    end

    assign in_ready  = en4;
    assign out_valid = v6_reg;
    assign out_data  = res_reg;

endmodule
